// ===== hw/rtl/ascii85_stream_encoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// ascii85_stream_encoder_core_assert.svh - assertion macros
// Shorthand for the concurrent checks of the Ascii85 encoder core.
// ----------------------------------------------------------------------------
`ifndef ASCII85_STREAM_ENCODER_CORE_ASSERT_SVH
`define ASCII85_STREAM_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define A85_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define A85_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/a85enc_pkg.sv =====
// ----------------------------------------------------------------------------
// a85enc_pkg - Ascii85 encoder package
// Sequencer states, character codes and the divide-by-85 reciprocal.
// ----------------------------------------------------------------------------
package a85enc_pkg;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_EMIT
	} a85enc_state_t;

	localparam int unsigned B85_BASE     = 85;
	localparam int unsigned B85_OFFSET   = 33;
	localparam int unsigned B85_DIGITS   = 5;
	localparam int unsigned DIGIT_W      = 7;

	// floor(v / 85) == (v * RECIP) >> RECIP_SHIFT for every 32-bit v
	localparam logic [31:0] RECIP        = 32'd3233857729;
	localparam int unsigned RECIP_SHIFT  = 38;
	localparam int unsigned QUOT_W       = 64 - RECIP_SHIFT;

	// digit value that prints as 'z' once the offset is added
	localparam logic [DIGIT_W-1:0] Z_DIGIT = 7'd89;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam logic [7:0] CH_GT    = 8'd62;
	localparam logic [7:0] CH_Z     = 8'd122;
	localparam logic [7:0] CH_LO    = 8'd33;
	localparam logic [7:0] CH_HI    = 8'd117;

	localparam logic [7:0] GPL_RESET = 8'd15;

endpackage

// ===== hw/rtl/ascii85_stream_encoder_core.sv =====
// ----------------------------------------------------------------------------
// ascii85_stream_encoder_core - Ascii85 stream encoder
// Packs bytes into groups of four and prints each group as five base-85
// characters (or 'z'), with line breaks and the closing "~>".
// ----------------------------------------------------------------------------
//
//  channel  | signals                               | flow
//  ---------+---------------------------------------+--------------------
//  input    | in_valid in_ready data_byte is_last   | one byte per transaction
//  output   | out_valid out_ready out_char out_last | one character per transaction
//  config   | cfg_we cfg_wdata                      | groups_per_line, no wait
//
// A byte that leaves the group open is only stored; the sequencer stays idle.
// A byte that closes a group starts the sequencer: the shared
// multiply-by-reciprocal unit steps through ST_MUL and ST_FIX once per digit for five digits,
// then one character per cycle, while the output is not stalled, leaves through the output register.
// An all-zero group of four bytes skips the divider. Reset is asynchronous, active low.
// A stalled output holds the sequencer; input is taken only when idle.
// ----------------------------------------------------------------------------
`include "ascii85_stream_encoder_core_assert.svh"

module ascii85_stream_encoder_core
	import a85enc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_last
);

	a85enc_state_t state_q, state_nxt;

	logic [7:0]          gpl_q;
	logic [23:0]         pend_bytes_q;
	logic [1:0]          pend_cnt_q;
	logic [7:0]          phase_q;
	logic [31:0]         val_q;
	logic [QUOT_W-1:0]   prod_q;
	logic [2:0]          div_cnt_q;
	logic [DIGIT_W-1:0]  d_q [B85_DIGITS];
	logic [2:0]          dig_left_q;
	logic                nl_q;
	logic                tl_q;
	logic                gt_q;
	logic                out_valid_q;
	logic [7:0]          out_char_q;
	logic                out_last_q;

	// sequencer outputs
	logic in_idle;
	logic mul_en;
	logic fix_en;
	logic emit_st;

	// ---------------- input side decode ----------------
	logic               in_fire;
	logic [2:0]         have;
	logic               store_only;
	logic [31:0]        acc;
	logic [31:0]        val_init;
	logic               is_zero;
	logic [8:0]         phase_inc;
	logic [7:0]         phase_nxt;

	assign in_fire    = in_valid && in_ready;
	assign have       = {1'b0, pend_cnt_q} + 3'd1;
	assign store_only = (have != 3'd4) && !is_last;
	assign acc        = {pend_bytes_q, data_byte};
	assign is_zero    = (pend_cnt_q == 2'd3) && (acc == 32'd0);
	assign phase_inc  = {1'b0, phase_q} + 9'd1;
	assign phase_nxt  = (phase_inc >= {1'b0, gpl_q}) ? 8'd0 : phase_inc[7:0];

	// left-align the group, padding with zero bytes
	always_comb begin
		case (pend_cnt_q)
			2'd0:    val_init = {data_byte, 24'd0};
			2'd1:    val_init = {pend_bytes_q[7:0], data_byte, 16'd0};
			2'd2:    val_init = {pend_bytes_q[15:0], data_byte, 8'd0};
			default: val_init = acc;
		endcase
	end

	// ---------------- shared divide-by-85 unit ----------------
	logic [63:0]        mul_full;
	logic [DIGIT_W-1:0] q_lo;
	logic [DIGIT_W-1:0] rem;

	assign mul_full = {32'd0, val_q} * {32'd0, RECIP};
	assign q_lo     = prod_q[DIGIT_W-1:0];
	// remainder is below 85, so seven low bits are enough
	assign rem      = val_q[DIGIT_W-1:0] - DIGIT_W'(q_lo * DIGIT_W'(B85_BASE));

	// ---------------- emit decode ----------------
	logic       emit_load;
	logic [7:0] emit_ch;
	logic       emit_more;

	assign emit_load = emit_st && (!out_valid_q || out_ready);

	always_comb begin
		if (dig_left_q != 3'd0) begin
			emit_ch   = 8'({1'b0, d_q[B85_DIGITS-1]}) + 8'(B85_OFFSET);
			emit_more = (dig_left_q > 3'd1) || nl_q || tl_q || gt_q;
		end else if (nl_q) begin
			emit_ch   = CH_NL;
			emit_more = tl_q || gt_q;
		end else if (tl_q) begin
			emit_ch   = CH_TILDE;
			emit_more = gt_q;
		end else begin
			emit_ch   = CH_GT;
			emit_more = 1'b0;
		end
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && !store_only) begin
					state_nxt = is_zero ? ST_EMIT : ST_MUL;
				end
			end
			ST_MUL: begin
				state_nxt = ST_FIX;
			end
			ST_FIX: begin
				if (div_cnt_q == 3'(B85_DIGITS - 1)) begin
					state_nxt = ST_EMIT;
				end else begin
					state_nxt = ST_MUL;
				end
			end
			ST_EMIT: begin
				if (emit_load && !emit_more) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_idle = 1'b0;
		mul_en  = 1'b0;
		fix_en  = 1'b0;
		emit_st = 1'b0;
		case (state_q)
			ST_IDLE: in_idle = 1'b1;
			ST_MUL:  mul_en  = 1'b1;
			ST_FIX:  fix_en  = 1'b1;
			ST_EMIT: emit_st = 1'b1;
			default: in_idle = 1'b0;
		endcase
	end

	assign in_ready = in_idle;

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			gpl_q        <= GPL_RESET;
			pend_bytes_q <= 24'd0;
			pend_cnt_q   <= 2'd0;
			phase_q      <= 8'd0;
			div_cnt_q    <= 3'd0;
			dig_left_q   <= 3'd0;
			nl_q         <= 1'b0;
			tl_q         <= 1'b0;
			gt_q         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg_we) begin
				gpl_q <= cfg_wdata;
			end

			// group bookkeeping on each accepted byte
			if (in_fire) begin
				if (store_only) begin
					pend_bytes_q <= acc[23:0];
					pend_cnt_q   <= have[1:0];
				end else begin
					pend_bytes_q <= 24'd0;
					pend_cnt_q   <= 2'd0;
					phase_q      <= is_last ? 8'd0 : phase_nxt;
					div_cnt_q    <= 3'd0;
					// n bytes print as n+1 digits
					dig_left_q   <= is_zero ? 3'd1 : have + 3'd1;
					nl_q         <= (phase_q == 8'd0);
					tl_q         <= is_last;
					gt_q         <= is_last;
				end
			end

			if (fix_en) begin
				div_cnt_q <= div_cnt_q + 3'd1;
			end

			// pop one character per output slot
			if (emit_load) begin
				if (dig_left_q != 3'd0) begin
					dig_left_q <= dig_left_q - 3'd1;
				end else if (nl_q) begin
					nl_q <= 1'b0;
				end else if (tl_q) begin
					tl_q <= 1'b0;
				end else begin
					gt_q <= 1'b0;
				end
			end

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_fire && !store_only) begin
			val_q <= val_init;
			if (is_zero) begin
				d_q[B85_DIGITS-1] <= Z_DIGIT;
			end
		end

		if (mul_en) begin
			prod_q <= mul_full[63:RECIP_SHIFT];
		end

		// digits come out least significant first and shift down from the top
		if (fix_en) begin
			val_q             <= 32'(prod_q);
			d_q[B85_DIGITS-1] <= rem;
			for (int i = 0; i < B85_DIGITS - 1; i++) begin
				d_q[i] <= d_q[i+1];
			end
		end

		if (emit_load) begin
			out_char_q <= emit_ch;
			out_last_q <= !emit_more;
			if (dig_left_q != 3'd0) begin
				for (int i = 1; i < B85_DIGITS; i++) begin
					d_q[i] <= d_q[i-1];
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	// ---------------- assertions ----------------
	`A85_ASSERT_NEXT(a_open_group_idle, clk, arst_n, in_fire && store_only, in_ready, "byte that leaves the group open must not start the sequencer")
	`A85_ASSERT_NOW(a_no_pending_busy, clk, arst_n, state_q != ST_IDLE, pend_cnt_q == 2'd0, "pending bytes left while a group is in flight")
	`A85_ASSERT_NOW(a_char_range, clk, arst_n, out_valid, ((out_char >= CH_LO) && (out_char <= CH_HI)) || (out_char == CH_Z) || (out_char == CH_NL) || (out_char == CH_TILDE) || (out_char == CH_GT), "character outside the Ascii85 alphabet")

endmodule
